@@ rtl/fptd_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed-priority task dispatcher package
// Operation and status codes, the task record kept in the task table and the
// result beat assembled by the sequencer.
// ----------------------------------------------------------------------------
package fptd_pkg;

   localparam logic [2:0] OP_ADD_PERIODIC  = 3'd0;
   localparam logic [2:0] OP_ADD_APERIODIC = 3'd1;
   localparam logic [2:0] OP_TRIGGER       = 3'd2;
   localparam logic [2:0] OP_DISPATCH      = 3'd3;
   localparam logic [2:0] OP_COMPLETE      = 3'd4;
   localparam logic [2:0] OP_READ_STATS    = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NONE      = 2'd2;
   localparam logic [1:0] ST_BAD_INDEX = 2'd3;

   localparam logic [7:0] NEVER_PRIO = 8'd255;

   typedef struct packed {
      logic [30:0] period;
      logic [31:0] due;
      logic [7:0]  prio;
      logic [31:0] runs;
      logic [31:0] longest;
      logic [31:0] missed;
   } task_rec_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  chosen_task;
      logic        deadline_missed;
      logic [31:0] runs;
      logic [31:0] longest_run;
      logic [31:0] missed_total;
   } rsp_beat_type;

endpackage

@@ rtl/fptd_req_if.sv @@
// ----------------------------------------------------------------------------
// Dispatcher request channel
// Valid/ready channel that carries one operation beat into the dispatcher.
// ----------------------------------------------------------------------------
interface fptd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [31:0] tick;
   logic [30:0] period;
   logic [7:0]  priority_req;
   logic [3:0]  task_index;

   modport source (output valid, operation, tick, period, priority_req, task_index,
                   input ready);
   modport sink   (input valid, operation, tick, period, priority_req, task_index,
                   output ready);
endinterface

@@ rtl/fptd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Dispatcher response channel
// Valid/ready channel that carries one result beat out of the dispatcher.
// ----------------------------------------------------------------------------
interface fptd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  chosen_task;
   logic        deadline_missed;
   logic [31:0] runs;
   logic [31:0] longest_run;
   logic [31:0] missed_total;

   modport source (output valid, status, chosen_task, deadline_missed, runs,
                   longest_run, missed_total, input ready);
   modport sink   (input valid, status, chosen_task, deadline_missed, runs,
                   longest_run, missed_total, output ready);
endinterface

@@ rtl/fptd_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// Dispatcher compare unit
// Decides whether one task record is ready at the current tick and whether it
// beats the best priority found so far in the scan.
// ----------------------------------------------------------------------------
module fptd_cmp_unit (
   input  fptd_pkg::task_rec_type rec,
   input  logic [31:0]            now,
   input  logic                   pending,
   input  logic [7:0]             best_prio,
   output logic                   take
);
   import fptd_pkg::*;

   logic [31:0] due_diff;
   logic        ready;

   // A periodic task is ready once the wrapping difference to its due time
   // is not negative; an aperiodic one only while pending.
   assign due_diff = now - rec.due;
   assign ready    = (rec.period != 31'd0) ? !due_diff[31] : pending;
   assign take     = ready && (rec.prio < best_prio);

endmodule

@@ rtl/fixed_priority_task_dispatcher_unit.sv @@
// ----------------------------------------------------------------------------
// Fixed-priority task dispatcher
// Add, trigger and unknown codes go from decode straight to the response
// state; read stats adds a table read, complete a read, an update and a
// write-back, and a dispatch walks the task table through one read port and
// one shared comparator. One request is in flight at a time; the next is
// accepted while the previous response still waits in the output register.
// Synchronous reset empties the table, clears pending flags and the
// dispatched mark; table contents are written by an add before use.
// ----------------------------------------------------------------------------
module fixed_priority_task_dispatcher_unit #(
   parameter int TASK_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   fptd_req_if.sink    req_chan,
   fptd_rsp_if.source  rsp_chan
);
   import fptd_pkg::*;

   localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CW = $clog2(TASK_SLOTS + 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_CPL_UPD  = 3'd3;
   localparam logic [2:0] S_CPL_WR   = 3'd4;
   localparam logic [2:0] S_STAT_OUT = 3'd5;
   localparam logic [2:0] S_RESP     = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [TASK_SLOTS-1:0] pending_ff, pending_in;
   logic                  disp_valid_ff, disp_valid_in;
   logic [AW-1:0]         disp_id_ff, disp_id_in;
   logic [31:0]           start_ff, start_in;

   logic [2:0]  op_ff, op_in;
   logic [31:0] tick_ff, tick_in;
   logic [30:0] per_ff, per_in;
   logic [7:0]  prio_ff, prio_in;
   logic [3:0]  idx_ff, idx_in;

   logic [CW-1:0] scan_ptr_ff, scan_ptr_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [7:0]    best_ff, best_in;
   logic          found_ff, found_in;
   logic [AW-1:0] pick_ff, pick_in;

   task_rec_type work_ff, work_in;
   rsp_beat_type res_ff, res_in;
   rsp_beat_type out_ff, out_in;
   logic         rsp_valid_ff, rsp_valid_in;

   task_rec_type task_mem [TASK_SLOTS];
   task_rec_type rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   task_rec_type  wr_data;

   logic        take;
   logic        idx_ok;
   logic        req_fire;
   logic [30:0] per_eff;
   logic [31:0] dur;
   logic [31:0] due_diff;

   fptd_cmp_unit u_cmp (
      .rec       (rd_data_ff),
      .now       (tick_ff),
      .pending   (pending_ff[cmp_idx_ff]),
      .best_prio (best_ff),
      .take      (take)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign idx_ok         = 8'(idx_ff) < 8'(count_ff);
   assign per_eff        = (op_ff == OP_ADD_PERIODIC) ? per_ff : 31'd0;
   assign dur            = tick_ff - start_ff;
   assign due_diff       = tick_ff - work_ff.due;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pending_in    = pending_ff;
      disp_valid_in = disp_valid_ff;
      disp_id_in    = disp_id_ff;
      start_in      = start_ff;
      op_in         = op_ff;
      tick_in       = tick_ff;
      per_in        = per_ff;
      prio_in       = prio_ff;
      idx_in        = idx_ff;
      scan_ptr_in   = scan_ptr_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      work_in       = work_ff;
      res_in        = res_ff;
      rd_addr       = disp_id_ff;
      wr_en         = 1'b0;
      wr_addr       = disp_id_ff;
      wr_data       = work_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_chan.operation;
               tick_in  = req_chan.tick;
               per_in   = req_chan.period;
               prio_in  = req_chan.priority_req;
               idx_in   = req_chan.task_index;
               res_in   = '0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            unique case (op_ff)
               OP_ADD_PERIODIC, OP_ADD_APERIODIC: begin
                  if (count_ff >= CW'(TASK_SLOTS)) begin
                     res_in.status = ST_FULL;
                  end else begin
                     wr_en           = 1'b1;
                     wr_addr         = AW'(count_ff);
                     wr_data.period  = per_eff;
                     wr_data.due     = tick_ff + {1'b0, per_eff};
                     wr_data.prio    = prio_ff;
                     wr_data.runs    = '0;
                     wr_data.longest = '0;
                     wr_data.missed  = '0;
                     pending_in[AW'(count_ff)] = 1'b0;
                     count_in            = count_ff + CW'(1);
                     res_in.chosen_task  = 4'(count_ff);
                  end
               end
               OP_TRIGGER: begin
                  res_in.chosen_task = idx_ff;
                  if (!idx_ok) begin
                     res_in.status = ST_BAD_INDEX;
                  end else begin
                     pending_in[AW'(idx_ff)] = 1'b1;
                  end
               end
               OP_DISPATCH: begin
                  scan_ptr_in = '0;
                  best_in     = NEVER_PRIO;
                  found_in    = 1'b0;
                  pick_in     = '0;
                  state_in    = S_SCAN;
               end
               OP_COMPLETE: begin
                  if (!disp_valid_ff) begin
                     res_in.status = ST_NONE;
                  end else begin
                     rd_addr  = disp_id_ff;
                     state_in = S_CPL_UPD;
                  end
               end
               OP_READ_STATS: begin
                  res_in.chosen_task = idx_ff;
                  if (!idx_ok) begin
                     res_in.status = ST_BAD_INDEX;
                  end else begin
                     rd_addr  = AW'(idx_ff);
                     state_in = S_STAT_OUT;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            // One table read is issued per cycle; its record is judged by the
            // compare unit in the following cycle.
            if (cmp_vld_ff && take) begin
               best_in  = rd_data_ff.prio;
               pick_in  = cmp_idx_ff;
               found_in = 1'b1;
            end
            if (scan_ptr_ff < count_ff) begin
               rd_addr     = AW'(scan_ptr_ff);
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = AW'(scan_ptr_ff);
               scan_ptr_in = scan_ptr_ff + CW'(1);
            end else if (!cmp_vld_ff) begin
               state_in = S_RESP;
               if (found_ff) begin
                  disp_valid_in      = 1'b1;
                  disp_id_in         = pick_ff;
                  start_in           = tick_ff;
                  res_in.chosen_task = 4'(pick_ff);
               end else begin
                  disp_valid_in = 1'b0;
                  res_in.status = ST_NONE;
               end
            end
         end
         S_CPL_UPD: begin
            work_in         = rd_data_ff;
            work_in.runs    = rd_data_ff.runs + 32'd1;
            work_in.longest = (dur > rd_data_ff.longest) ? dur : rd_data_ff.longest;
            work_in.due     = rd_data_ff.due + {1'b0, rd_data_ff.period};
            disp_valid_in   = 1'b0;
            state_in        = S_CPL_WR;
         end
         S_CPL_WR: begin
            wr_en   = 1'b1;
            wr_addr = disp_id_ff;
            wr_data = work_ff;
            if (work_ff.period != 31'd0) begin
               if (due_diff != 32'd0 && !due_diff[31]) begin
                  wr_data.missed         = work_ff.missed + 32'd1;
                  res_in.deadline_missed = 1'b1;
               end
            end else begin
               pending_in[disp_id_ff] = 1'b0;
            end
            res_in.chosen_task  = 4'(disp_id_ff);
            res_in.runs         = wr_data.runs;
            res_in.longest_run  = wr_data.longest;
            res_in.missed_total = wr_data.missed;
            state_in            = S_RESP;
         end
         S_STAT_OUT: begin
            res_in.runs         = rd_data_ff.runs;
            res_in.longest_run  = rd_data_ff.longest;
            res_in.missed_total = rd_data_ff.missed;
            state_in            = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loaded when the sequencer finishes and the slot is free.
   always_comb begin
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_RESP && (!rsp_valid_ff || rsp_chan.ready)) begin
         out_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pending_ff    <= '0;
         disp_valid_ff <= 1'b0;
         disp_id_ff    <= '0;
         start_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         cmp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pending_ff    <= pending_in;
         disp_valid_ff <= disp_valid_in;
         disp_id_ff    <= disp_id_in;
         start_ff      <= start_in;
         rsp_valid_ff  <= rsp_valid_in;
         cmp_vld_ff    <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tick_ff     <= tick_in;
      per_ff      <= per_in;
      prio_ff     <= prio_in;
      idx_ff      <= idx_in;
      scan_ptr_ff <= scan_ptr_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_ff     <= best_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      work_ff     <= work_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
   end

   // Task table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         task_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= task_mem[rd_addr];
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = out_ff.status;
   assign rsp_chan.chosen_task     = out_ff.chosen_task;
   assign rsp_chan.deadline_missed = out_ff.deadline_missed;
   assign rsp_chan.runs            = out_ff.runs;
   assign rsp_chan.longest_run     = out_ff.longest_run;
   assign rsp_chan.missed_total    = out_ff.missed_total;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TASK_SLOTS))
      else $error("task count exceeds the table size");

   a_disp_in_table: assert property (@(posedge clock) disable iff (reset)
      disp_valid_ff |-> (CW'(disp_id_ff) < count_ff))
      else $error("dispatched task lies outside the filled table");

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_DECODE))
      else $error("accepted beat was not decoded");

   a_rsp_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESP))
      else $error("response raised without a finished operation");

   a_scan_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_ptr_ff <= count_ff))
      else $error("scan pointer ran past the filled table");
`endif

endmodule
